// ===== hw/rtl/biquad_pkg.sv =====
// biquad_pkg: shared types, constants and codes of the biquad iir filter unit
`timescale 1ns / 1ps

package biquad_pkg;

  // sample format is fixed by the payload structs
  localparam int SAMPLE_WIDTH  = 16;
  localparam int COEF_WIDTH_DEF = 32;
  localparam int ACC_WIDTH_DEF  = 48;
  localparam int CFG_IDX_WIDTH  = 3;

  // configuration register indexes, also used as coefficient selects
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_B0,
    ST_ROUND,
    ST_N1_ADD,
    ST_N1_SUB,
    ST_N2_ADD,
    ST_N2_SUB
  } bq_state_e;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           clear_history;
  } bq_in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           clipped;
  } bq_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic     load_in;     // capture request, clear delays if asked
    cfg_reg_e coef_sel;    // multiplier coefficient operand
    logic     mul_y;       // multiplier sample operand: 1 = output, 0 = input
    logic     prod_en;     // register multiplier result
    logic     y_en;        // round and saturate output
    logic     acc_en;      // accumulate product
    logic     acc_add_d2;  // accumulate adds second delay term
    logic     d1_en;       // write first delay term
    logic     d2_en;       // write second delay term
    logic     out_en;      // load result register
  } bq_cmd_t;

endpackage

// ===== hw/rtl/biquad_ctrl.sv =====
// biquad_ctrl: sequencer for one sample through the shared multiplier
`timescale 1ns / 1ps

module biquad_ctrl import biquad_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output bq_cmd_t cmd_o
);

  bq_state_e state_q, state_d;
  logic      out_valid_q, out_valid_d;
  logic      out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.coef_sel = REG_B0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_MUL_B0;
        end
      end
      ST_MUL_B0: begin
        cmd_o.coef_sel = REG_B0;
        cmd_o.prod_en  = 1'b1;
        state_d        = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.y_en     = 1'b1;
        cmd_o.coef_sel = REG_B1;
        cmd_o.prod_en  = 1'b1;
        state_d        = ST_N1_ADD;
      end
      ST_N1_ADD: begin
        cmd_o.acc_en     = 1'b1;
        cmd_o.acc_add_d2 = 1'b1;
        cmd_o.coef_sel   = REG_A1;
        cmd_o.mul_y      = 1'b1;
        cmd_o.prod_en    = 1'b1;
        state_d          = ST_N1_SUB;
      end
      ST_N1_SUB: begin
        cmd_o.d1_en    = 1'b1;
        cmd_o.coef_sel = REG_B2;
        cmd_o.prod_en  = 1'b1;
        state_d        = ST_N2_ADD;
      end
      ST_N2_ADD: begin
        cmd_o.acc_en   = 1'b1;
        cmd_o.coef_sel = REG_A2;
        cmd_o.mul_y    = 1'b1;
        cmd_o.prod_en  = 1'b1;
        state_d        = ST_N2_SUB;
      end
      ST_N2_SUB: begin
        // hold here while the previous result has not been taken
        if (out_free) begin
          cmd_o.d2_en  = 1'b1;
          cmd_o.out_en = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/biquad_dp.sv =====
// biquad_dp: coefficients, shared multiplier, accumulator and delay terms
`timescale 1ns / 1ps

module biquad_dp import biquad_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int ACC_WIDTH  = ACC_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [COEF_WIDTH-1:0]    cfg_data_i,
  input  bq_in_t                   in_data_i,
  input  bq_cmd_t                  cmd_i,
  output bq_out_t                  out_data_o
);

  localparam int ProdWidth = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int SumWidth  = ((ProdWidth > ACC_WIDTH) ? ProdWidth : ACC_WIDTH) + 2;
  localparam int RndShift  = COEF_WIDTH - 4;

  logic signed [COEF_WIDTH-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
  logic signed [SAMPLE_WIDTH-1:0] x_q, y_q;
  logic signed [ACC_WIDTH-1:0]    d1_q, d2_q;
  logic signed [ProdWidth-1:0]    prod_q, prod_d;
  logic signed [SumWidth-1:0]     acc_q, acc_d;
  logic                           clip_q;
  bq_out_t                        out_q;

  logic signed [COEF_WIDTH-1:0]   mul_a;
  logic signed [SAMPLE_WIDTH-1:0] mul_b;
  logic signed [SumWidth-1:0]     rnd_sum, y_wide, dly_sum;
  logic [SumWidth-SAMPLE_WIDTH:0] y_hi;
  logic [SumWidth-ACC_WIDTH:0]    dly_hi;
  logic                           y_ovf, dly_ovf;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic signed [ACC_WIDTH-1:0]    dly_sat;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= COEF_WIDTH'(1) << RndShift;
      b1_q <= '0;
      b2_q <= '0;
      a1_q <= '0;
      a2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_B0:  b0_q <= cfg_data_i;
        REG_B1:  b1_q <= cfg_data_i;
        REG_B2:  b2_q <= cfg_data_i;
        REG_A1:  a1_q <= cfg_data_i;
        REG_A2:  a2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared multiplier
  always_comb begin
    case (cmd_i.coef_sel)
      REG_B0:  mul_a = b0_q;
      REG_B1:  mul_a = b1_q;
      REG_B2:  mul_a = b2_q;
      REG_A1:  mul_a = a1_q;
      REG_A2:  mul_a = a2_q;
      default: mul_a = '0;
    endcase
  end

  assign mul_b  = cmd_i.mul_y ? y_q : x_q;
  assign prod_d = mul_a * mul_b;

  // output rounding: add half, floor shift, saturate
  assign rnd_sum = SumWidth'(prod_q) + SumWidth'(d1_q) + (SumWidth'(1) <<< (RndShift - 1));
  assign y_wide  = rnd_sum >>> RndShift;
  assign y_hi    = y_wide[SumWidth-1:SAMPLE_WIDTH-1];
  assign y_ovf   = !((&y_hi) || !(|y_hi));
  assign y_sat   = y_ovf ? (y_wide[SumWidth-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                               : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}})
                         : y_wide[SAMPLE_WIDTH-1:0];

  // delay update: accumulated feedforward minus feedback product, saturate
  assign acc_d   = SumWidth'(prod_q) + (cmd_i.acc_add_d2 ? SumWidth'(d2_q) : '0);
  assign dly_sum = acc_q - SumWidth'(prod_q);
  assign dly_hi  = dly_sum[SumWidth-1:ACC_WIDTH-1];
  assign dly_ovf = !((&dly_hi) || !(|dly_hi));
  assign dly_sat = dly_ovf ? (dly_sum[SumWidth-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                                  : {1'b0, {(ACC_WIDTH-1){1'b1}}})
                           : dly_sum[ACC_WIDTH-1:0];

  // delay terms
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else begin
      if (cmd_i.load_in && in_data_i.clear_history) begin
        d1_q <= '0;
        d2_q <= '0;
      end else begin
        if (cmd_i.d1_en) begin
          d1_q <= dly_sat;
        end
        if (cmd_i.d2_en) begin
          d2_q <= dly_sat;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q    <= in_data_i.sample_in;
      clip_q <= 1'b0;
    end else begin
      if (cmd_i.y_en) begin
        clip_q <= clip_q | y_ovf;
      end else if (cmd_i.d1_en) begin
        clip_q <= clip_q | dly_ovf;
      end
    end
    if (cmd_i.prod_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.y_en) begin
      y_q <= y_sat;
    end
    if (cmd_i.acc_en) begin
      acc_q <= acc_d;
    end
    if (cmd_i.out_en) begin
      out_q.sample_out <= y_q;
      out_q.clipped    <= clip_q | dly_ovf;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== hw/rtl/biquad_iir_filter_unit.sv =====
// biquad_iir_filter_unit: top level of the fixed-point transposed direct form ii biquad
`timescale 1ns / 1ps

// channel   direction  handshake                   payload
// in        request    in_valid_i / in_ready_o      in_data_i  (sample_in, clear_history)
// out       result     out_valid_o / out_ready_i    out_data_o (sample_out, clipped)
// cfg       write      cfg_we_i, no wait            cfg_idx_i, cfg_data_i
//
// a request is taken in the idle step, then five products go through one shared
// coefficient-by-sample multiplier, each registered before it is added, so a new
// request is taken only once the previous one has reached the result register.
// rst_ni clears the sequencer, result valid, both delay terms and loads the
// coefficient reset values (b0 = 1.0, others 0). a request is taken while the
// previous result still waits; if that result is still not taken when the next
// one is done, the sequencer holds in its last step until the output register frees.

module biquad_iir_filter_unit import biquad_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int ACC_WIDTH  = ACC_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration writes
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [COEF_WIDTH-1:0]    cfg_data_i,
  // sample requests
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  bq_in_t                   in_data_i,
  // filtered results
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output bq_out_t                  out_data_o
);

  // command bundle from the sequencer to the datapath
  bq_cmd_t cmd;

  // sequencer: walks b0*x, round, b1*x, a1*y, b2*x, a2*y and owns both handshakes
  biquad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // datapath: coefficient registers, multiplier, accumulator, delay terms, result
  biquad_dp #(
    .COEF_WIDTH (COEF_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .out_data_o (out_data_o)
  );

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for the biquad iir filter unit with a bit-true filter predictor
`timescale 1ns / 1ps

module tb_top;
  import biquad_pkg::*;

  // fixed-point layout of the default build
  localparam int FRAC_SHIFT = COEF_WIDTH_DEF - 4;   // q4.28 coefficient fraction bits
  localparam int NUM_COEFS  = 5;

  // run control
  localparam int     SETTLE_CYCLES = 12;            // idle wait after the last result
  localparam int     HOLD_CYCLES   = 300;           // long output stall for the fill-up test
  localparam int     PER_SETTING   = 27;            // random requests per coefficient set
  localparam longint TIMEOUT_NS    = 1_600_000;     // far above a slow run

  // notable operand values
  localparam logic signed [SAMPLE_WIDTH-1:0]   S_MAX  = 16'sh7fff;
  localparam logic signed [SAMPLE_WIDTH-1:0]   S_MIN  = 16'sh8000;
  localparam logic signed [COEF_WIDTH_DEF-1:0] C_MAX  = 32'sh7fff_ffff;
  localparam logic signed [COEF_WIDTH_DEF-1:0] C_MIN  = 32'sh8000_0000;
  localparam logic signed [COEF_WIDTH_DEF-1:0] C_ONE  = 32'sh1000_0000;
  localparam logic signed [COEF_WIDTH_DEF-1:0] C_HALF = 32'sh0800_0000;

  // one full coefficient set, entry i goes to register index i
  typedef logic [NUM_COEFS-1:0][COEF_WIDTH_DEF-1:0] coef_set_t;

  // flavors of coefficient sets used by the random traffic
  typedef enum int {
    MIX_WILD,     // any 32-bit pattern, saturates a lot
    MIX_GENTLE,   // stable low-gain section
    MIX_TOP,      // every coefficient at its most positive
    MIX_BOTTOM,   // every coefficient at its most negative
    MIX_UNITY     // reset values, plain pass-through
  } coef_mix_e;

  // dut ports
  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i   = '0;
  logic [COEF_WIDTH_DEF-1:0] cfg_data_i  = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  bq_in_t                    in_data_i   = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  bq_out_t                   out_data_o;

  // filter predictor: coefficient copy and both delay terms
  logic signed [COEF_WIDTH_DEF-1:0] coef_now [NUM_COEFS] = '{C_ONE, '0, '0, '0, '0};
  longint                           dly_one = 0;
  longint                           dly_two = 0;
  bq_out_t                          filtered_q [$];   // predicted outputs, oldest first

  // traffic shaping
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        rx_hold       = 1'b0;   // forces out_ready_i low while set
  bit          tx_live       = 1'b0;   // in_valid_i still high for a request already taken
  int          mismatches    = 0;

  biquad_iir_filter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // clamp to the nearest value of a w-bit two's complement number
  function automatic longint clamp_bits(input longint v, input int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // one sample through the transposed direct form ii section, advances the delays
  function automatic bq_out_t filter_step(input bq_in_t req);
    longint  x, acc, y_raw, y, n1, n2, d1_new, d2_new;
    logic    clip;
    bq_out_t res;
    x = longint'($signed(req.sample_in));
    if (req.clear_history) begin
      dly_one = 0;
      dly_two = 0;
    end
    // output: q.43 accumulator rounded half up to q1.15, then saturated
    acc   = longint'(coef_now[REG_B0]) * x + dly_one;
    y_raw = (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    y     = clamp_bits(y_raw, SAMPLE_WIDTH);
    clip  = (y != y_raw);
    // delay updates use the saturated output, feedback terms are subtracted
    n1 = longint'(coef_now[REG_B1]) * x - longint'(coef_now[REG_A1]) * y + dly_two;
    n2 = longint'(coef_now[REG_B2]) * x - longint'(coef_now[REG_A2]) * y;
    d1_new = clamp_bits(n1, ACC_WIDTH_DEF);
    d2_new = clamp_bits(n2, ACC_WIDTH_DEF);
    clip = clip | (d1_new != n1) | (d2_new != n2);
    dly_one = d1_new;
    dly_two = d2_new;
    res.sample_out = y[SAMPLE_WIDTH-1:0];
    res.clipped    = clip;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // out_ready_i: random idling unless a long hold-off is running
  always @(posedge clk_i) begin
    if (rx_hold) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic note_fail(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  // every accepted result is compared with the oldest prediction
  always @(posedge clk_i) begin : result_check
    bq_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (filtered_q.size() == 0) begin
        note_fail($sformatf("result with nothing pending: sample_out %0d clipped %0b",
                            $signed(out_data_o.sample_out), out_data_o.clipped));
      end else begin
        want = filtered_q.pop_front();
        if (out_data_o.sample_out !== want.sample_out)
          note_fail($sformatf("sample_out mismatch: expected %0d, got %0d",
                              $signed(want.sample_out), $signed(out_data_o.sample_out)));
        if (out_data_o.clipped !== want.clipped)
          note_fail($sformatf("clipped mismatch: expected %0b, got %0b",
                              want.clipped, out_data_o.clipped));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side and configuration
  // ---------------------------------------------------------------------------

  // drop in_valid_i if it still holds a request that was already taken
  task automatic tx_quiet();
    if (tx_live) begin
      in_valid_i <= 1'b0;
      tx_live = 1'b0;
    end
  endtask

  // offer one request, predict its result once it is taken
  task automatic send_sample(input bq_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      tx_quiet();
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    tx_live = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    filtered_q.push_back(filter_step(req));
  endtask

  task automatic send_value(input logic signed [SAMPLE_WIDTH-1:0] s, input logic clr);
    bq_in_t req;
    req.sample_in     = s;
    req.clear_history = clr;
    send_sample(req);
  endtask

  // stop offering, wait for every predicted result, then let the block settle
  task automatic quiesce(input int settle);
    tx_quiet();
    do @(posedge clk_i); while (filtered_q.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  // back-to-back register writes from index first on; only the five real
  // registers change the predictor, other indexes must be ignored by the block
  task automatic cfg_write_run(input logic [CFG_IDX_WIDTH-1:0] first, input int count,
                               input coef_set_t vals);
    logic [CFG_IDX_WIDTH-1:0] idx;
    idx = first;
    for (int k = 0; k < count; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= vals[k];
      @(posedge clk_i);
      if (idx <= REG_A2) coef_now[idx] = vals[k];
      idx = idx + 1'b1;
    end
    cfg_we_i <= 1'b0;
  endtask

  // new coefficient set, only ever while the block is idle
  task automatic reprogram(input coef_set_t s);
    quiesce(SETTLE_CYCLES);
    cfg_write_run(REG_B0, NUM_COEFS, s);
  endtask

  function automatic logic [COEF_WIDTH_DEF-1:0] spread(input int m);
    return COEF_WIDTH_DEF'(int'($urandom_range(0, 2 * m)) - m);
  endfunction

  function automatic coef_set_t pick_coefs(input coef_mix_e mix);
    coef_set_t s;
    int        a2_mag;
    s = '0;
    case (mix)
      MIX_WILD: begin
        for (int i = 0; i < NUM_COEFS; i++) s[i] = $urandom();
      end
      MIX_GENTLE: begin
        for (int i = REG_B0; i <= REG_B2; i++) s[i] = spread(int'(C_HALF));
        // keep the poles inside the unit circle: |a2| < 1, |a1| < 1 + a2
        a2_mag    = $urandom_range(0, 7 * (1 << 25));
        s[REG_A2] = COEF_WIDTH_DEF'(a2_mag);
        s[REG_A1] = spread(int'(C_ONE) + a2_mag - (1 << 24));
      end
      MIX_TOP:    s = {NUM_COEFS{C_MAX}};
      MIX_BOTTOM: s = {NUM_COEFS{C_MIN}};
      default:    s[REG_B0] = C_ONE;
    endcase
    return s;
  endfunction

  // mostly random samples, some at the rails, an occasional history clear
  function automatic bq_in_t pick_sample();
    bq_in_t req;
    case ($urandom_range(15))
      0:       req.sample_in = S_MAX;
      1:       req.sample_in = S_MIN;
      default: req.sample_in = SAMPLE_WIDTH'($urandom());
    endcase
    req.clear_history = ($urandom_range(19) == 0);
    return req;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset coefficients give y = x exactly, including both rails
  task automatic test_reset_passthrough();
    send_value('0, 1'b1);
    send_value(S_MAX, 1'b0);
    send_value(S_MIN, 1'b0);
    send_value(-16'sd1, 1'b0);
    send_value(16'sd1, 1'b1);
  endtask

  // writes to indexes past the last register leave every coefficient alone
  task automatic test_ignored_index();
    coef_set_t junk;
    junk = pick_coefs(MIX_WILD);
    quiesce(SETTLE_CYCLES);
    cfg_write_run(CFG_IDX_WIDTH'(REG_A2 + 1), (1 << CFG_IDX_WIDTH) - 1 - int'(REG_A2), junk);
    send_value(S_MAX, 1'b0);
    send_value(16'sd12345, 1'b0);
  endtask

  // b0 near 8.0 drives the output into both rails
  task automatic test_output_clip();
    coef_set_t s;
    s = '0;
    s[REG_B0] = C_MAX;
    reprogram(s);
    send_value(S_MAX, 1'b1);
    send_value(S_MIN, 1'b0);
    send_value(16'sd1, 1'b0);
    send_value(-16'sd1, 1'b0);
  endtask

  // b0 = 0.5 puts odd samples exactly on the half step, which rounds up
  task automatic test_round_half();
    coef_set_t s;
    s = '0;
    s[REG_B0] = C_HALF;
    reprogram(s);
    send_value(16'sd1, 1'b1);
    send_value(-16'sd1, 1'b0);
    send_value(16'sd3, 1'b0);
    send_value(-16'sd3, 1'b0);
  endtask

  // feedforward and feedback terms add up so the first delay term saturates,
  // a history clear in the middle restarts from zero
  task automatic test_delay_clip();
    coef_set_t s;
    s = {C_MIN, C_MIN, C_MAX, C_MAX, C_MAX};   // a2, a1, b2, b1, b0
    reprogram(s);
    send_value(S_MAX, 1'b1);
    send_value(S_MAX, 1'b0);
    send_value(S_MIN, 1'b0);
    send_value(S_MIN, 1'b0);
    send_value('0, 1'b1);
    send_value(S_MIN, 1'b0);
    send_value(S_MAX, 1'b0);
  endtask

  // random requests through every coefficient flavor under one idling pattern
  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct);
    send_idle_pct = tx_pct;
    recv_idle_pct = rx_pct;
    for (int m = MIX_WILD; m <= MIX_UNITY; m++) begin
      reprogram(pick_coefs(coef_mix_e'(m)));
      repeat (PER_SETTING) send_sample(pick_sample());
    end
  endtask

  // output held off long enough that the block fills and stalls its input,
  // then a sender pause until every result is back before streaming again
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    reprogram(pick_coefs(MIX_GENTLE));
    fork
      begin
        @(negedge clk_i);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    repeat (12) send_sample(pick_sample());
    quiesce(0);
    repeat (8) send_sample(pick_sample());
    quiesce(0);
    repeat (8) send_sample(pick_sample());
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed part runs under the first idling pattern
    send_idle_pct = 36;
    recv_idle_pct = 65;
    test_reset_passthrough();
    test_ignored_index();
    test_output_clip();
    test_round_half();
    test_delay_clip();

    test_random_traffic(36, 65);
    test_random_traffic(65, 36);
    test_random_traffic(0, 0);
    test_backpressure();

    quiesce(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
